[hdl/npfe_pkg.sv]
// Package for the nearest-point-on-feature-edges block.
// Holds payload structs, mode and status codes, and controller/datapath command types.
`timescale 1ns / 1ps
package npfe_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned DiffW    = 33;
  localparam int unsigned ProdW    = 66;
  localparam int unsigned WideW    = 68;
  localparam int unsigned DistW    = 64;
  localparam int unsigned UCntW    = $clog2(FracBits + 1);

  localparam logic [1:0] ModeEdge   = 2'd0;
  localparam logic [1:0] ModeCorner = 2'd1;
  localparam logic [1:0] ModeError  = 2'd2;
  localparam logic [1:0] ModeSpare  = 2'd3;

  localparam logic [1:0] StatProj   = 2'd0;
  localparam logic [1:0] StatCorner = 2'd1;
  localparam logic [1:0] StatNone   = 2'd2;
  localparam logic [1:0] StatError  = 2'd3;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [CoordW-1:0] guess_x;
    logic signed [CoordW-1:0] guess_y;
    logic signed [CoordW-1:0] guess_z;
    logic signed [CoordW-1:0] own_x;
    logic signed [CoordW-1:0] own_y;
    logic signed [CoordW-1:0] own_z;
    logic signed [CoordW-1:0] neighbour_x;
    logic signed [CoordW-1:0] neighbour_y;
    logic signed [CoordW-1:0] neighbour_z;
    logic                     last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic [1:0]               status;
  } out_item_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OpNone, OpLoad, OpDiff, OpProd, OpDivStep, OpLerp, OpDist, OpKeep
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] axis;
    logic       clear;
  } dp_cmd_t;

  typedef struct packed {
    logic valid_seg;
    logic u_nonzero;
  } dp_stat_t;

endpackage

[hdl/npfe_datapath.sv]
// Datapath: differences, products, restoring divider, interpolation and best-candidate registers.
// Depends on npfe_pkg; driven by npfe_ctrl through command and status structs.
`timescale 1ns / 1ps
module npfe_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  npfe_pkg::dp_cmd_t  cmd_i,
  input  npfe_pkg::in_item_t item_i,
  output npfe_pkg::dp_stat_t stat_o,
  output logic              have_best_o,
  output logic [npfe_pkg::CoordW-1:0] best_x_o,
  output logic [npfe_pkg::CoordW-1:0] best_y_o,
  output logic [npfe_pkg::CoordW-1:0] best_z_o
);
  import npfe_pkg::*;

  logic signed [CoordW-1:0] g_q [3];
  logic signed [CoordW-1:0] n_q [3];
  logic signed [CoordW-1:0] o_q [3];
  logic signed [DiffW-1:0]  d_q [3];
  logic signed [DiffW-1:0]  w_q [3];
  logic signed [CoordW-1:0] p_q [3];
  logic signed [WideW-1:0]  dot_q, len2_q;
  logic [WideW-1:0]         rem_q;
  logic [FracBits-1:0]      u_q;
  logic [DistW:0]           dist_q;
  logic                     have_q;
  logic [DistW-1:0]         bestd_q;
  logic [CoordW-1:0]        bx_q, by_q, bz_q;

  logic signed [DiffW-1:0]  dsel, wsel;
  logic signed [ProdW-1:0]  pdw, pdd;
  logic [WideW-1:0]         rsh, rsub;
  logic signed [DiffW+FracBits:0] up;
  logic signed [DiffW:0]    lq, gdiff;
  logic [ProdW-1:0]         sq;
  logic [DistW:0]           dsum;

  // Per-axis product, interpolation and distance terms for the selected axis, and the divider step.
  always_comb begin
    dsel  = d_q[cmd_i.axis];
    wsel  = w_q[cmd_i.axis];
    pdw   = ProdW'(wsel) * ProdW'(dsel);
    pdd   = ProdW'(dsel) * ProdW'(dsel);
    rsh   = {rem_q[WideW-2:0], 1'b0};
    rsub  = rsh - $unsigned(len2_q);
    up    = $signed({1'b0, u_q}) * dsel;
    lq    = DiffW'(up >>> FracBits) + DiffW'(n_q[cmd_i.axis]);
    gdiff = (DiffW+1)'(g_q[cmd_i.axis]) - (DiffW+1)'(p_q[cmd_i.axis]);
    sq    = ProdW'(gdiff) * ProdW'(gdiff);
    dsum  = dist_q + (DistW+1)'(sq[DistW-1:0]);
  end

  // Clocked datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q <= '{default: '0};
      n_q <= '{default: '0};
      o_q <= '{default: '0};
      d_q <= '{default: '0};
      w_q <= '{default: '0};
      p_q <= '{default: '0};
      dot_q  <= '0;
      len2_q <= '0;
      rem_q  <= '0;
      u_q    <= '0;
      dist_q <= '0;
      have_q  <= 1'b0;
      bestd_q <= '1;
      bx_q <= '0; by_q <= '0; bz_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OpLoad: begin
          g_q[0] <= item_i.guess_x; g_q[1] <= item_i.guess_y; g_q[2] <= item_i.guess_z;
          o_q[0] <= item_i.own_x;   o_q[1] <= item_i.own_y;   o_q[2] <= item_i.own_z;
          n_q[0] <= item_i.neighbour_x; n_q[1] <= item_i.neighbour_y;
          n_q[2] <= item_i.neighbour_z;
          dot_q  <= '0; len2_q <= '0; dist_q <= '0; u_q <= '0;
        end
        OpDiff: begin
          for (int i = 0; i < 3; i++) begin
            d_q[i] <= DiffW'(o_q[i]) - DiffW'(n_q[i]);
            w_q[i] <= DiffW'(g_q[i]) - DiffW'(n_q[i]);
          end
        end
        OpProd: begin
          dot_q  <= dot_q + WideW'(pdw);
          len2_q <= len2_q + WideW'(pdd);
          rem_q  <= $unsigned(dot_q + WideW'(pdw));
        end
        OpDivStep: begin
          if (!rsub[WideW-1] || rsh >= $unsigned(len2_q)) begin
            rem_q <= rsub;
            u_q   <= {u_q[FracBits-2:0], 1'b1};
          end else begin
            rem_q <= rsh;
            u_q   <= {u_q[FracBits-2:0], 1'b0};
          end
        end
        OpLerp: p_q[cmd_i.axis] <= CoordW'(lq);
        OpDist: begin
          if (sq[ProdW-1:DistW] != '0 || dsum[DistW] || dist_q[DistW]) begin
            dist_q <= {1'b1, {DistW{1'b1}}};
          end else begin
            dist_q <= dsum;
          end
        end
        OpKeep: begin
          if (!have_q || DistW'(dist_q[DistW] ? '1 : dist_q[DistW-1:0]) < bestd_q) begin
            have_q  <= 1'b1;
            bestd_q <= dist_q[DistW] ? '1 : dist_q[DistW-1:0];
            bx_q <= p_q[0]; by_q <= p_q[1]; bz_q <= p_q[2];
          end
        end
        default: ;
      endcase
      if (cmd_i.clear) begin
        have_q  <= 1'b0;
        bestd_q <= '1;
        bx_q <= '0; by_q <= '0; bz_q <= '0;
      end
    end
  end

  // Segment validity: nonzero length and 0 < dot < len2.
  assign stat_o.valid_seg = (len2_q != '0) && (dot_q > 0) && (dot_q < len2_q);
  assign stat_o.u_nonzero = (u_q != '0);
  assign have_best_o = have_q;
  assign best_x_o = bx_q;
  assign best_y_o = by_q;
  assign best_z_o = bz_q;

endmodule

[hdl/npfe_ctrl.sv]
// Controller state machine sequencing the datapath for one request.
// Depends on npfe_pkg; commands npfe_datapath.
`timescale 1ns / 1ps
module npfe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  npfe_pkg::in_item_t  item_i,
  input  npfe_pkg::dp_stat_t  stat_i,
  input  logic               have_best_i,
  input  logic [npfe_pkg::CoordW-1:0] best_x_i,
  input  logic [npfe_pkg::CoordW-1:0] best_y_i,
  input  logic [npfe_pkg::CoordW-1:0] best_z_i,
  output npfe_pkg::dp_cmd_t   cmd_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output npfe_pkg::out_item_t out_o
);
  import npfe_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDiff, StProd, StDiv, StLerp, StDist, StKeep, StEmit
  } state_e;

  state_e              state_q;
  logic [1:0]          axis_q;
  logic [UCntW-1:0]    cnt_q;
  logic [1:0]          mode_q;
  logic                last_q;
  logic [CoordW-1:0]   ox_q, oy_q, oz_q;
  out_item_t           out_q;
  logic                ovalid_q;
  logic                accept;

  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

  // Command decode from the current state.
  always_comb begin
    cmd_o.op    = OpNone;
    cmd_o.axis  = axis_q;
    cmd_o.clear = 1'b0;
    unique case (state_q)
      StIdle: if (accept) cmd_o.op = OpLoad;
      StDiff: cmd_o.op = OpDiff;
      StProd: cmd_o.op = OpProd;
      StDiv:  cmd_o.op = OpDivStep;
      StLerp: cmd_o.op = OpLerp;
      StDist: cmd_o.op = OpDist;
      StKeep: cmd_o.op = OpKeep;
      StEmit: cmd_o.clear = !out_stall_i || !ovalid_q;
      default: ;
    endcase
  end

  // State, counters and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      axis_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      mode_q   <= '0;
      last_q   <= 1'b0;
      ox_q     <= '0;
      oy_q     <= '0;
      oz_q     <= '0;
      out_q    <= '0;
    end else begin
      // The emit state loads the next result itself.
      if (ovalid_q && !out_stall_i && state_q != StEmit) ovalid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            mode_q <= item_i.mode;
            last_q <= item_i.last_item;
            ox_q <= item_i.own_x; oy_q <= item_i.own_y; oz_q <= item_i.own_z;
            axis_q <= '0;
            state_q <= (item_i.mode == ModeEdge) ? StDiff : StEmit;
          end
        end
        StDiff: state_q <= StProd;
        StProd: begin
          if (axis_q == 2'd2) begin
            axis_q <= '0;
            cnt_q  <= '0;
            state_q <= StDiv;
          end else begin
            axis_q <= axis_q + 2'd1;
          end
        end
        StDiv: begin
          if (!stat_i.valid_seg) begin
            state_q <= last_q ? StEmit : StIdle;
          end else if (cnt_q == UCntW'(FracBits - 1)) begin
            state_q <= StLerp;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StLerp: begin
          if (!stat_i.u_nonzero) begin
            state_q <= last_q ? StEmit : StIdle;
          end else if (axis_q == 2'd2) begin
            axis_q <= '0;
            state_q <= StDist;
          end else begin
            axis_q <= axis_q + 2'd1;
          end
        end
        StDist: begin
          if (axis_q == 2'd2) begin
            axis_q <= '0;
            state_q <= StKeep;
          end else begin
            axis_q <= axis_q + 2'd1;
          end
        end
        StKeep: state_q <= last_q ? StEmit : StIdle;
        StEmit: begin
          if (!ovalid_q || !out_stall_i) begin
            ovalid_q <= 1'b1;
            state_q  <= StIdle;
            if (mode_q == ModeEdge && have_best_i) begin
              out_q <= '{out_x: best_x_i, out_y: best_y_i, out_z: best_z_i,
                         status: StatProj};
            end else begin
              out_q.out_x <= ox_q; out_q.out_y <= oy_q; out_q.out_z <= oz_q;
              priority if (mode_q == ModeEdge) out_q.status <= StatNone;
              else if (mode_q == ModeCorner)   out_q.status <= StatCorner;
              else                             out_q.status <= StatError;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

[hdl/nearest_point_on_feature_edges.sv]
// Top level: snaps a guessed point onto the nearest feature edge of a boundary point.
// Depends on npfe_pkg, npfe_ctrl and npfe_datapath.
//
//   channel  | handshake               | payload
//   input    | in_valid_i / in_stall_o | in_item_i  (npfe_pkg::in_item_t)
//   output   | out_valid_o / out_stall_i | out_item_o (npfe_pkg::out_item_t)
//
// An edge request runs, from one accept to the next, one load, one difference,
// three product steps, 16 restoring-divider steps for u, then three interpolation,
// three distance and one compare step; an invalid segment or a zero u ends it early.
// A last edge request adds one emit step. Corner and error requests skip to emit.
// Reset clears the kept candidate. A result waits in the output register while the
// output stalls; the next request is still taken and held back only at its own emit.
`timescale 1ns / 1ps
module nearest_point_on_feature_edges (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  npfe_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output npfe_pkg::out_item_t out_item_o
);
  import npfe_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic              have_best;
  logic [CoordW-1:0] bx, by, bz;

  npfe_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .item_i(in_item_i),
    .stat_i(stat), .have_best_i(have_best), .best_x_i(bx), .best_y_i(by),
    .best_z_i(bz), .cmd_o(cmd), .out_valid_o, .out_stall_i, .out_o(out_item_o)
  );

  npfe_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(in_item_i), .stat_o(stat),
    .have_best_o(have_best), .best_x_o(bx), .best_y_o(by), .best_z_o(bz)
  );

endmodule

[tb/nearest_point_on_feature_edges_tb.sv]
// Testbench for nearest_point_on_feature_edges: directed and random request groups.
// Depends on npfe_pkg and the nearest_point_on_feature_edges RTL.
`timescale 1ns / 1ps

// Tracks the nearest kept edge point per group and checks emitted points.
class snap_scoreboard;
  npfe_pkg::out_item_t pending_points[$];
  bit                  have_best;
  logic [63:0]         best_dist;
  logic [31:0]         best_x, best_y, best_z;
  int                  errors;

  function new();
    errors = 0;
    clear_group();
  endfunction

  function void clear_group();
    have_best = 1'b0;
    best_dist = '1;
    best_x = '0;
    best_y = '0;
    best_z = '0;
  endfunction

  // Projects the guess onto one segment and keeps it when it is nearer.
  function void try_segment(npfe_pkg::in_item_t it);
    logic signed [33:0]  g[3], o[3], n[3], d[3], w[3];
    logic signed [69:0]  dot, len2, rem;
    logic [16:0]         u;
    logic signed [69:0]  prod, q;
    logic signed [33:0]  p[3];
    logic signed [34:0]  diff;
    logic [69:0]         sq, dist_acc;
    begin
      g[0] = it.guess_x; g[1] = it.guess_y; g[2] = it.guess_z;
      o[0] = it.own_x; o[1] = it.own_y; o[2] = it.own_z;
      n[0] = it.neighbour_x; n[1] = it.neighbour_y; n[2] = it.neighbour_z;
      dot = 0;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = o[i] - n[i];
        w[i] = g[i] - n[i];
        dot += 70'(w[i]) * 70'(d[i]);
        len2 += 70'(d[i]) * 70'(d[i]);
      end
      if (len2 == 0 || dot <= 0 || dot >= len2) return;
      // Restoring division for the 16-bit fraction of u.
      rem = dot;
      u = 0;
      for (int i = 0; i < npfe_pkg::FracBits; i++) begin
        rem = rem <<< 1;
        u = u << 1;
        if (rem >= len2) begin
          rem -= len2;
          u[0] = 1'b1;
        end
      end
      if (u == 0) return;
      dist_acc = 0;
      for (int i = 0; i < 3; i++) begin
        prod = 70'(signed'({1'b0, u})) * 70'(d[i]);
        q = prod >>> npfe_pkg::FracBits;
        p[i] = n[i] + 34'(q);
        diff = 35'(g[i]) - 35'(p[i]);
        sq = 70'(diff) * 70'(diff);
        dist_acc += sq;
      end
      if (dist_acc > 70'(64'hFFFF_FFFF_FFFF_FFFF)) dist_acc = 70'(64'hFFFF_FFFF_FFFF_FFFF);
      if (!have_best || dist_acc[63:0] < best_dist) begin
        have_best = 1'b1;
        best_dist = dist_acc[63:0];
        best_x = p[0][31:0];
        best_y = p[1][31:0];
        best_z = p[2][31:0];
      end
    end
  endfunction

  // Notes an accepted request and queues the point it causes, if any.
  function void note_request(npfe_pkg::in_item_t it);
    npfe_pkg::out_item_t r;
    begin
      r.out_x = it.own_x;
      r.out_y = it.own_y;
      r.out_z = it.own_z;
      if (it.mode == npfe_pkg::ModeEdge) begin
        try_segment(it);
        if (!it.last_item) return;
        if (have_best) begin
          r.out_x = best_x;
          r.out_y = best_y;
          r.out_z = best_z;
          r.status = npfe_pkg::StatProj;
        end else begin
          r.status = npfe_pkg::StatNone;
        end
      end else if (it.mode == npfe_pkg::ModeCorner) begin
        r.status = npfe_pkg::StatCorner;
      end else begin
        r.status = npfe_pkg::StatError;
      end
      clear_group();
      pending_points.push_back(r);
    end
  endfunction

  // Compares one emitted point with the oldest pending one.
  function void check_point(npfe_pkg::out_item_t act);
    npfe_pkg::out_item_t exp_pt;
    begin
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, act);
        return;
      end
      exp_pt = pending_points.pop_front();
      if (act.out_x !== exp_pt.out_x) begin
        errors++;
        $display("%0t: out_x expected %h actual %h", $time, exp_pt.out_x, act.out_x);
      end
      if (act.out_y !== exp_pt.out_y) begin
        errors++;
        $display("%0t: out_y expected %h actual %h", $time, exp_pt.out_y, act.out_y);
      end
      if (act.out_z !== exp_pt.out_z) begin
        errors++;
        $display("%0t: out_z expected %h actual %h", $time, exp_pt.out_z, act.out_z);
      end
      if (act.status !== exp_pt.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, exp_pt.status, act.status);
      end
    end
  endfunction
endclass

module nearest_point_on_feature_edges_tb;
  import npfe_pkg::*;

  localparam int NumRandom  = 2000;
  localparam int WatchLimit = 20000;
  localparam int DrainWait  = 60;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b1;
  out_item_t out_item_o;

  snap_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  long_hold = 1'b0;

  nearest_point_on_feature_edges u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #4 clk_i = ~clk_i;

  // Sends one request, after a random gap, and waits for it to be accepted.
  // Valid stays high into the next request when the gap is zero.
  task automatic send_request(in_item_t it);
    int gap;
    begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_item_i  <= it;
      in_valid_i <= 1'b1;
      do @(posedge clk_i); while (in_stall_o);
      sb.note_request(it);
      @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: rand_coord = 32'h8000_0000;
      1: rand_coord = 32'h7FFF_FFFF;
      2: rand_coord = $urandom_range(0, 4095) - 2048;
      default: rand_coord = $urandom;
    endcase
  endfunction

  // Builds an edge request with a guess near the segment so that most project.
  function automatic in_item_t edge_request(bit last);
    in_item_t it;
    logic signed [31:0] base, spanv;
    begin
      it = '0;
      it.mode = ModeEdge;
      it.last_item = last;
      if ($urandom_range(0, 4) == 0) begin
        {it.guess_x, it.guess_y, it.guess_z} = {rand_coord(), rand_coord(), rand_coord()};
        {it.own_x, it.own_y, it.own_z} = {rand_coord(), rand_coord(), rand_coord()};
        {it.neighbour_x, it.neighbour_y, it.neighbour_z} =
          {rand_coord(), rand_coord(), rand_coord()};
      end else begin
        for (int i = 0; i < 3; i++) begin
          base  = $urandom;
          base  = base >>> $urandom_range(0, 12);
          spanv = $urandom;
          spanv = spanv >>> $urandom_range(4, 16);
          case (i)
            0: begin
              it.neighbour_x = base; it.own_x = base + spanv;
              it.guess_x = base + (spanv >>> 1) + $urandom_range(0, 65535) - 32768;
            end
            1: begin
              it.neighbour_y = base; it.own_y = base + spanv;
              it.guess_y = base + (spanv >>> 1) + $urandom_range(0, 65535) - 32768;
            end
            default: begin
              it.neighbour_z = base; it.own_z = base + spanv;
              it.guess_z = base + (spanv >>> 1) + $urandom_range(0, 65535) - 32768;
            end
          endcase
        end
      end
      edge_request = it;
    end
  endfunction

  // Receiver: random stalls, one long hold-off, checks at the rising edge.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end
      hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_point(out_item_o);
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus: directed cases, then random groups.
  initial begin
    in_item_t it;
    int       grp;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Corner, error and unused mode, with extreme coordinates.
    it = '0;
    it.own_x = 32'h7FFF_FFFF; it.own_y = 32'h8000_0000; it.own_z = '1;
    it.mode = ModeCorner; send_request(it);
    it.mode = ModeError; it.last_item = 1'b1; send_request(it);
    it.mode = ModeSpare; send_request(it);
    // Zero-length segment, last item.
    it = '0; it.mode = ModeEdge; it.last_item = 1'b1;
    it.own_x = 32'h0001_0000; it.neighbour_x = 32'h0001_0000;
    send_request(it);
    // Guess beyond the end, then before the start: no projection.
    it.neighbour_x = 0; it.own_x = 32'h0001_0000; it.guess_x = 32'h0002_0000;
    send_request(it);
    it.guess_x = 32'hFFFF_0000; send_request(it);
    // Guess at the very start, u rounding to zero.
    it.own_x = 32'h7FFF_FFFF; it.neighbour_x = 32'h8000_0000;
    it.guess_x = 32'h8000_0001; send_request(it);
    // Two candidates, second nearer; then a tie.
    it = '0; it.mode = ModeEdge;
    it.own_x = 32'h0004_0000; it.guess_x = 32'h0001_0000; it.guess_y = 32'h0003_0000;
    send_request(it);
    it.guess_y = 32'h0003_0000; it.own_y = 32'h0002_0000; it.own_x = 32'h0004_0000;
    send_request(it);
    it.last_item = 1'b1; send_request(it);
    // Extreme span from min to max on every axis.
    it = '0; it.mode = ModeEdge; it.last_item = 1'b1;
    {it.neighbour_x, it.neighbour_y, it.neighbour_z} = {3{32'h8000_0000}};
    {it.own_x, it.own_y, it.own_z} = {3{32'h7FFF_FFFF}};
    {it.guess_x, it.guess_y, it.guess_z} = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
    send_request(it);
    // Edge group cut short by a corner.
    send_request(edge_request(1'b0));
    it.mode = ModeCorner; it.last_item = 1'b0; send_request(it);

    // Random groups; the long receiver hold-off fires partway through.
    grp = 0;
    for (int k = 0; k < NumRandom; ) begin
      int len;
      if (grp == 20) long_hold = 1'b1;
      grp++;
      case ($urandom_range(0, 9))
        0: begin
          it = edge_request(1'b0);
          it.mode = 2'($urandom_range(int'(ModeCorner), int'(ModeSpare)));
          it.last_item = $urandom_range(0, 1);
          send_request(it);
          k++;
        end
        default: begin
          len = $urandom_range(1, 4);
          for (int j = 0; j < len; j++) begin
            send_request(edge_request(j == len - 1));
            k++;
          end
        end
      endcase
    end
    in_valid_i <= 1'b0;

    // Drain and finish.
    while (sb.pending_points.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/npfe_pkg.sv
hdl/npfe_datapath.sv
hdl/npfe_ctrl.sv
hdl/nearest_point_on_feature_edges.sv
tb/nearest_point_on_feature_edges_tb.sv
